[design/brl_pkg.sv]
// Shared constants and request codes for the Bresenham line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

    // Default coordinate width in bits (signed two's complement pixels).
    localparam int COORD_BITS_DEF = 12;

    // Extra bits carried by the decision term beyond the coordinate width.
    localparam int DEC_EXTRA_BITS = 4;

    // Request codes on req_type.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

[design/bresenham_line_rasterizer.sv]
// Top level of the Bresenham line rasterizer: all-octant integer line stepping.
`timescale 1ns / 1ps

// Channel  Signals                                    Direction  Moves
// -------  -----------------------------------------  ---------  ----------------------------
// req      req_valid req_ready req_type x_start       in         one start or step word
//          y_start x_end y_end
// res      res_valid res_ready point_valid pixel_x    out        one pixel word per req word
//          pixel_y last_point
//
// Every accepted request word yields exactly one result word in the next cycle, and a new
// request word can be taken in every cycle while result words are taken, so a line of N
// pixels streams at one pixel per clock. The rate holds because the state update (adds
// and a sign test on the decision term) is combinational from line state to result register.
// Reset clears the line state to idle and empties the result register.
// When the result register holds a word that is not taken, req_ready drops, so no
// request word is accepted until room is made; the two sides are parted by that register.

module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         req_type,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,

    output logic                         res_valid,
    input  logic                         res_ready,
    output logic                         point_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last_point
);

    // The decision term spans [-2*major, 2*minor]; DEC_BITS adds DEC_EXTRA_BITS (4) bits of headroom.
    localparam int DEC_BITS = COORD_BITS + brl_pkg::DEC_EXTRA_BITS;
    localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    // Line state.
    logic [COORD_BITS-1:0]      cur_x_reg,       cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg,       cur_y_next;
    logic signed [DEC_BITS-1:0] decision_reg,    decision_next;
    logic [COORD_BITS-1:0]      abs_dx_reg,      abs_dx_next;
    logic [COORD_BITS-1:0]      abs_dy_reg,      abs_dy_next;
    logic                       step_x_neg_reg,  step_x_neg_next;
    logic                       step_y_neg_reg,  step_y_neg_next;
    logic                       y_major_reg,     y_major_next;
    logic [COORD_BITS-1:0]      steps_left_reg,  steps_left_next;
    logic                       line_active_reg, line_active_next;

    // Result register.
    logic                       res_valid_reg;
    logic                       point_valid_reg, point_valid_next;
    logic [COORD_BITS-1:0]      pixel_x_reg,     pixel_x_next;
    logic [COORD_BITS-1:0]      pixel_y_reg,     pixel_y_next;
    logic                       last_point_reg,  last_point_next;

    // Start path: endpoint deltas, one bit wider so that the full span fits.
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        mag_dx;
    logic [COORD_BITS:0]        mag_dy;
    logic [COORD_BITS-1:0]      s_major;
    logic [COORD_BITS-1:0]      s_minor;
    logic                       s_y_major;

    // Step path.
    logic [COORD_BITS-1:0]      c_major;
    logic [COORD_BITS-1:0]      c_minor;
    logic                       both;
    logic [COORD_BITS-1:0]      x_moved;
    logic [COORD_BITS-1:0]      y_moved;
    logic [COORD_BITS-1:0]      steps_dec;

    logic                       req_accept;

    // A request is taken whenever the result register is empty or is being emptied.
    assign req_ready  = !res_valid_reg || res_ready;
    assign req_accept = req_valid && req_ready;

    always_comb
    begin
        dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        mag_dx = dx[COORD_BITS] ? -dx : dx;
        mag_dy = dy[COORD_BITS] ? -dy : dy;
        // The span of two coordinates is below 2^COORD_BITS, so the low bits hold it.
        s_y_major = mag_dy[COORD_BITS-1:0] > mag_dx[COORD_BITS-1:0];
        s_major   = s_y_major ? mag_dy[COORD_BITS-1:0] : mag_dx[COORD_BITS-1:0];
        s_minor   = s_y_major ? mag_dx[COORD_BITS-1:0] : mag_dy[COORD_BITS-1:0];

        c_major   = y_major_reg ? abs_dy_reg : abs_dx_reg;
        c_minor   = y_major_reg ? abs_dx_reg : abs_dy_reg;
        // A non-negative decision moves the minor axis as well as the major one.
        both      = !decision_reg[DEC_BITS-1];
        x_moved   = step_x_neg_reg ? cur_x_reg - ONE : cur_x_reg + ONE;
        y_moved   = step_y_neg_reg ? cur_y_reg - ONE : cur_y_reg + ONE;
        steps_dec = steps_left_reg - ONE;

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        decision_next    = decision_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        y_major_next     = y_major_reg;
        steps_left_next  = steps_left_reg;
        line_active_next = line_active_reg;

        point_valid_next = 1'b0;
        pixel_x_next     = '0;
        pixel_y_next     = '0;
        last_point_next  = 1'b0;

        unique case (req_type)
            brl_pkg::REQ_START:
            begin
                // A start drops any line in progress and returns the start pixel at once.
                cur_x_next       = x_start;
                cur_y_next       = y_start;
                abs_dx_next      = mag_dx[COORD_BITS-1:0];
                abs_dy_next      = mag_dy[COORD_BITS-1:0];
                step_x_neg_next  = dx[COORD_BITS];
                step_y_neg_next  = dy[COORD_BITS];
                y_major_next     = s_y_major;
                decision_next    =
                    $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, s_minor, 1'b0})
                    - $signed({{(DEC_BITS-COORD_BITS){1'b0}}, s_major});
                steps_left_next  = s_major;
                line_active_next = (s_major != '0);
                point_valid_next = 1'b1;
                pixel_x_next     = x_start;
                pixel_y_next     = y_start;
                last_point_next  = (s_major == '0);
            end
            brl_pkg::REQ_STEP:
            begin
                // A step while idle leaves the state alone and returns an empty word.
                if (line_active_reg)
                begin
                    if (y_major_reg || both)
                    begin
                        cur_y_next = y_moved;
                    end
                    if (!y_major_reg || both)
                    begin
                        cur_x_next = x_moved;
                    end
                    decision_next = both
                        ? decision_reg
                          + $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, c_minor, 1'b0})
                          - $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, c_major, 1'b0})
                        : decision_reg
                          + $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, c_minor, 1'b0});
                    steps_left_next  = steps_dec;
                    line_active_next = (steps_dec != '0);
                    point_valid_next = 1'b1;
                    pixel_x_next     = (!y_major_reg || both) ? x_moved : cur_x_reg;
                    pixel_y_next     = (y_major_reg || both) ? y_moved : cur_y_reg;
                    last_point_next  = (steps_dec == '0);
                end
            end
            default:
            begin
                point_valid_next = 1'b0;
            end
        endcase
    end

    // Line state: cleared to idle by reset, updated on every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            decision_reg    <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            y_major_reg     <= 1'b0;
            steps_left_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            decision_reg    <= decision_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            y_major_reg     <= y_major_next;
            steps_left_reg  <= steps_left_next;
            line_active_reg <= line_active_next;
        end
    end

    // Result valid flag: set by an accepted request, cleared when the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is only looked at while res_valid is high.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            point_valid_reg <= point_valid_next;
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            last_point_reg  <= last_point_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign point_valid = point_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign last_point  = last_point_reg;

endmodule

[design/brl_checker.sv]
// Port-level assertions for the Bresenham line rasterizer, bound to the top level.
`timescale 1ns / 1ps

module brl_checker #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_type,
    input logic signed [COORD_BITS-1:0] x_start,
    input logic signed [COORD_BITS-1:0] y_start,
    input logic signed [COORD_BITS-1:0] x_end,
    input logic signed [COORD_BITS-1:0] y_end,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         point_valid,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic                         last_point
);

    logic req_start_accept;

    assign req_start_accept = req_valid && req_ready && (req_type == brl_pkg::REQ_START);

    // A result word that is not taken stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped before it was taken");

    // With no result pending, the block must be able to take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled while result register is empty");

    // Every accepted start returns its start pixel as a valid point in the next cycle.
    a_start_echo: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && req_start_accept |=>
            res_valid && point_valid
            && pixel_x == $past(x_start) && pixel_y == $past(y_start))
        else $error("start request did not return its start pixel");

    // A start with equal endpoints is a one-pixel line and marks that pixel last.
    a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && req_start_accept && x_start == x_end && y_start == y_end |=>
            last_point)
        else $error("single-pixel line not marked as last");

    // An empty result word carries zero fields.
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !point_valid |-> !last_point && pixel_x == '0 && pixel_y == '0)
        else $error("empty result word carries nonzero fields");

endmodule

bind bresenham_line_rasterizer brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (.*);
